@@ src/swm_pkg.sv @@
// Shared constants and types for the star wildcard name matcher.
package swm_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int POS_W       = 6;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 2;

	localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
	localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_NAME  = 2'd1,
		CMD_CLEAR = 2'd2
	} swm_cmd_t;

	// Broadcast to every cell.
	typedef struct packed {
		logic              name_step;
		logic              restart;
		logic [BYTE_W-1:0] data;
	} swm_ctl_t;

	// Handed from cell i to cell i+1.
	typedef struct packed {
		logic step;
		logic init;
	} swm_link_t;

endpackage

@@ src/swm_cell.sv @@
// One pattern position: its byte, its active bit, and the star propagation.
module swm_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::swm_ctl_t              ctl,
	input  logic                           wr_sel,
	input  logic                           active_rst,
	input  logic                           in_range_cur,
	input  logic                           in_range_new,
	input  swm_pkg::swm_link_t             link_in,
	output swm_pkg::swm_link_t             link_out,
	output logic                           step_next,
	output logic                           active,
	output logic [swm_pkg::BYTE_W-1:0]     pat_byte
);
	import swm_pkg::*;

	logic [BYTE_W-1:0] byte_q;
	logic              active_q;
	logic [BYTE_W-1:0] byte_new;
	logic              star_cur;
	logic              star_new;
	logic              gen;

	assign byte_new = wr_sel ? ctl.data : byte_q;
	assign star_cur = (byte_q == STAR_BYTE);
	assign star_new = (byte_new == STAR_BYTE);

	// literal match moves right; a live star keeps itself
	assign gen       = active_q & in_range_cur & ~star_cur & (byte_q == ctl.data);
	assign step_next = link_in.step | (active_q & in_range_cur & star_cur);

	assign link_out.step = gen | (step_next & in_range_cur & star_cur);
	assign link_out.init = link_in.init & in_range_new & star_new;

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			byte_q <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= active_rst;
		end else if (ctl.restart) begin
			active_q <= link_in.init;
		end else if (ctl.name_step) begin
			active_q <= step_next;
		end
	end

	assign active   = active_q;
	assign pat_byte = byte_q;

endmodule

@@ src/star_wildcard_name_matcher_top.sv @@
// Top level of the star wildcard name matcher: cell chain, name counters, result stages.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, command, pattern_position,  | into block
//          | byte_value, last                                |
//  out     | out_valid, out_ready, matched                   | out of block
//
// One item per cycle while in_ready is high, any command. A row of PATTERN_MAX cells
// holds the pattern bytes and the active position set; each name byte updates all cells
// together, with star runs rippling cell to cell like a carry chain.
// The final name byte's result goes through the snapshot stage and the output register.
// Reset gives an empty pattern; pattern bytes are undefined until loaded.
// in_ready drops only when a result sits in the snapshot stage and the output is stalled.
module star_wildcard_name_matcher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [swm_pkg::POS_W-1:0]      pattern_position,
	input  logic [swm_pkg::BYTE_W-1:0]     byte_value,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           matched
);
	import swm_pkg::*;

	logic                   acc;
	logic                   is_load;
	logic                   is_name;
	logic                   is_clear;
	logic                   do_write;
	swm_ctl_t               ctl;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       len_d;
	logic [CNT_W-1:0]       nb_q;
	logic [CNT_W-1:0]       ld_q;
	logic [CNT_W-1:0]       nb_new;
	logic [CNT_W-1:0]       ld_new;
	logic                   pat_dot;
	logic                   dot_fail;
	logic                   tail_q;
	swm_link_t              link [PATTERN_MAX+1];
	logic [PATTERN_MAX:0]   step_vec;
	logic [PATTERN_MAX:0]   act_vec;
	logic [BYTE_W-1:0]      pbyte [PATTERN_MAX];

	// result pipeline
	logic                   vld_s1;
	logic [PATTERN_MAX:0]   snap_s1;
	logic [LEN_W-1:0]       len_s1;
	logic                   fail_s1;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   out_adv;
	logic                   res_take;

	assign out_adv  = ~out_valid_q | out_ready;
	assign in_ready = ~vld_s1 | out_adv;
	assign acc      = in_valid & in_ready;

	always_comb begin
		is_load  = 1'b0;
		is_name  = 1'b0;
		is_clear = 1'b0;
		unique case (command)
			CMD_LOAD:  is_load  = 1'b1;
			CMD_NAME:  is_name  = 1'b1;
			CMD_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
	end

	// positions past the store are dropped without touching the name state
	assign do_write = acc & is_load &
		({1'b0, pattern_position} < (POS_W+1)'(PATTERN_MAX));

	assign res_take      = acc & is_name & last;
	assign ctl.data      = byte_value;
	assign ctl.restart   = do_write | (acc & is_clear) | res_take;
	assign ctl.name_step = acc & is_name & ~last;

	always_comb begin
		len_d = len_q;
		if (acc & is_clear) begin
			len_d = '0;
		end else if (do_write & last) begin
			len_d = LEN_W'(pattern_position) + LEN_W'(1);
		end
	end

	// cell chain; position zero seeds the restart closure
	assign link[0].step = 1'b0;
	assign link[0].init = 1'b1;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		swm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.wr_sel       (do_write & (pattern_position == POS_W'(i))),
			.active_rst   ((i == 0) ? 1'b1 : 1'b0),
			.in_range_cur (LEN_W'(i) < len_q),
			.in_range_new (LEN_W'(i) < len_d),
			.link_in      (link[i]),
			.link_out     (link[i+1]),
			.step_next    (step_vec[i]),
			.active       (act_vec[i]),
			.pat_byte     (pbyte[i])
		);
	end

	// position past the last pattern byte
	assign step_vec[PATTERN_MAX] = link[PATTERN_MAX].step;
	assign act_vec[PATTERN_MAX]  = tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (ctl.restart) begin
			tail_q <= link[PATTERN_MAX].init;
		end else if (ctl.name_step) begin
			tail_q <= step_vec[PATTERN_MAX];
		end
	end

	// saturating name length and leading dot run
	assign nb_new = (nb_q != '1) ? nb_q + CNT_W'(1) : nb_q;
	assign ld_new = ((ld_q == nb_q) && (byte_value == DOT_BYTE) && (ld_q != '1)) ?
		ld_q + CNT_W'(1) : ld_q;

	assign pat_dot  = (len_q != '0) && (pbyte[0] == DOT_BYTE);
	// hidden names need a dotted pattern; "." and ".." never match
	assign dot_fail = ((ld_new != '0) && !pat_dot) ||
		((ld_new == nb_new) && ((nb_new == CNT_W'(1)) || (nb_new == CNT_W'(2))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			nb_q  <= '0;
			ld_q  <= '0;
		end else begin
			len_q <= len_d;
			if (ctl.restart) begin
				nb_q <= '0;
				ld_q <= '0;
			end else if (ctl.name_step) begin
				nb_q <= nb_new;
				ld_q <= ld_new;
			end
		end
	end

	// snapshot stage: the updated set is captured before the cells restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (res_take) begin
			vld_s1 <= 1'b1;
		end else if (out_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			snap_s1 <= step_vec;
			len_s1  <= len_q;
			fail_s1 <= dot_fail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv & vld_s1) begin
			matched_q <= snap_s1[len_s1] & ~fail_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_adv |=> vld_s1)
		else $error("snapshot lost while output stalled");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("input stalled with empty snapshot stage");

	a_clear_resets_set: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_clear |=> act_vec == (PATTERN_MAX+1)'(1))
		else $error("clear did not leave only position zero active");

	a_dots_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ld_q <= nb_q)
		else $error("leading dot count exceeds name length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(PATTERN_MAX))
		else $error("pattern length beyond store");

endmodule
